/* rtl/core/h264_access_unit_boundary_detector_unit_defines.svh */
// Assertion macros shared by the access unit boundary detector RTL.
`ifndef H264_ACCESS_UNIT_BOUNDARY_DETECTOR_UNIT_DEFINES_SVH
`define H264_ACCESS_UNIT_BOUNDARY_DETECTOR_UNIT_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk and disabled during reset.
`define AUBD_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define AUBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define AUBD_ASSERT_IMPLY(lbl, ante, cons, msg)

`define AUBD_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/core/aubd_pkg.sv */
// Types, constants and helpers shared by the access unit boundary detector.
package aubd_pkg;

  localparam int INDEX_BITS      = 32;
  localparam int COUNT_BITS      = 16;
  localparam int UNIT_BITS       = 32;
  localparam int KIND_BITS       = 5;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int IN_DATA_BITS    = 200;
  localparam int OUT_DATA_BITS   = 168;

  // Item classes produced by the front end.
  typedef logic [1:0] cls_t;
  localparam cls_t CLS_FINISH = 2'd0;
  localparam cls_t CLS_VCL    = 2'd1;
  localparam cls_t CLS_PREFIX = 2'd2;
  localparam cls_t CLS_OTHER  = 2'd3;

  // NAL unit type codes that matter for grouping.
  localparam logic [4:0] NAL_SLICE  = 5'd1;
  localparam logic [4:0] NAL_IDR    = 5'd5;
  localparam logic [4:0] NAL_SEI    = 5'd6;
  localparam logic [4:0] NAL_AUD    = 5'd9;
  localparam logic [4:0] NAL_PFX_LO = 5'd14;
  localparam logic [4:0] NAL_PFX_HI = 5'd18;

  localparam logic [2:0] KIND_MAX = 3'd4;

  typedef logic [INDEX_BITS-1:0] index_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic [15:0]        frame_number;
    logic [7:0]         pps_id;
    logic               field;
    logic               bottom;
    logic               idr;
    logic               reference;
    logic [15:0]        poc_lsb;
    logic signed [31:0] delta_poc_bottom;
    logic signed [31:0] delta_poc_first;
    logic signed [31:0] delta_poc_second;
    logic [15:0]        idr_picture_id;
  } slice_t;

  typedef struct packed {
    cls_t                 cls;
    index_t               pos;
    logic [KIND_BITS-1:0] kind_bit;
    slice_t               slice;
  } item_t;

  // Members run from the top bit down, so unit_number lands in the lowest bits.
  typedef struct packed {
    logic [KIND_BITS-1:0] slice_kinds_seen;
    count_t               vcl_total;
    count_t               nal_total;
    index_t               last_nal;
    index_t               first_vcl_nal;
    index_t               first_nal;
    logic [UNIT_BITS-1:0] unit_number;
  } result_t;

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

/* rtl/core/h264_access_unit_boundary_detector_unit.sv */
// Top level of the H.264 access unit boundary detector.
//
//   channel | direction | tdata bits | tuser   | note
//   in_     | slave     | 200        | command | one parsed NAL header per word
//   out_    | master    | 168        | none    | one completed access unit per word
//
// One input word can be taken per cycle while in_tready is high; the front end
// decodes it into a QUEUE_DEPTH-entry queue and the back end retires one queued
// word per cycle while no result waits; out_tvalid and out_tdata are registered.
// While a result waits for out_tready the back end holds and the queue takes up
// to QUEUE_DEPTH more words before in_tready falls.
// Synchronous reset clears the queue, counters and flags.
module h264_access_unit_boundary_detector_unit
  import aubd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // nal_position, unit_type, picture_flags, frame_number, pps_id, poc_lsb,
  // delta_poc_bottom, delta_poc_first, delta_poc_second, idr_picture_id,
  // slice_kind, zero padding
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  // command
  input  logic                     in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // unit_number, first_nal, first_vcl_nal, last_nal, nal_total, vcl_total,
  // slice_kinds_seen, zero padding
  output logic [OUT_DATA_BITS-1:0] out_tdata
);

  logic  push_valid;
  item_t push_item;
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  aubd_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_item  (push_item)
  );

  aubd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (in_tready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop),
    .pop_item   (q_item)
  );

  aubd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* rtl/core/aubd_front.sv */
// Front end: unpacks an input word and classifies the NAL unit it carries.
module aubd_front
  import aubd_pkg::*;
(
  input  logic                    in_tvalid,
  input  logic [IN_DATA_BITS-1:0] in_tdata,
  input  logic                    in_tuser,
  output logic                    push_valid,
  output item_t                   push_item
);

  logic [4:0] unit_type;
  logic [4:0] flags;
  logic [2:0] slice_kind;
  cls_t       nal_cls;

  assign unit_type  = in_tdata[36:32];
  assign flags      = in_tdata[41:37];
  assign slice_kind = in_tdata[196:194];

  always_comb begin
    unique case (unit_type) inside
      NAL_SLICE, NAL_IDR:      nal_cls = flags[0] ? CLS_VCL : CLS_OTHER;
      [NAL_SEI:NAL_AUD]:       nal_cls = CLS_PREFIX;
      [NAL_PFX_LO:NAL_PFX_HI]: nal_cls = CLS_PREFIX;
      default:                 nal_cls = CLS_OTHER;
    endcase
  end

  always_comb begin
    push_item.cls      = in_tuser ? CLS_FINISH : nal_cls;
    push_item.pos      = in_tdata[INDEX_BITS-1:0];
    // Kinds above SI leave the mask untouched.
    push_item.kind_bit = (slice_kind <= KIND_MAX) ? KIND_BITS'(5'd1 << slice_kind) : '0;
    push_item.slice.frame_number     = in_tdata[57:42];
    push_item.slice.pps_id           = in_tdata[65:58];
    push_item.slice.field            = flags[1];
    push_item.slice.bottom           = flags[2];
    push_item.slice.idr              = flags[3];
    push_item.slice.reference        = flags[4];
    push_item.slice.poc_lsb          = in_tdata[81:66];
    push_item.slice.delta_poc_bottom = in_tdata[113:82];
    push_item.slice.delta_poc_first  = in_tdata[145:114];
    push_item.slice.delta_poc_second = in_tdata[177:146];
    push_item.slice.idr_picture_id   = in_tdata[193:178];
  end

  assign push_valid = in_tvalid;

endmodule

/* rtl/core/aubd_queue.sv */
// Short queue of classified items between the front end and the back end.
`include "h264_access_unit_boundary_detector_unit_defines.svh"

module aubd_queue
  import aubd_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              push;
  logic              pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `AUBD_ASSERT_IMPLY(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "queue count above depth")
  `AUBD_ASSERT_NEXT(a_count_grow, push && !pop, count_r == CNT_W'($past(count_r) + 1'b1), "queue count did not grow on push")
  `AUBD_ASSERT_NEXT(a_rd_follows, pop && !push, rd_ptr_r != $past(rd_ptr_r) || DEPTH == 1, "read pointer stuck on pop")

endmodule

/* rtl/core/aubd_back.sv */
// Back end: access unit state, picture change detection and the result register.
`include "h264_access_unit_boundary_detector_unit_defines.svh"

module aubd_back
  import aubd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  output logic                     q_pop,
  input  item_t                    q_item,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata
);

  localparam int OUT_PAD = OUT_DATA_BITS - $bits(result_t);

  logic                 open_r, open_nxt;
  logic [UNIT_BITS-1:0] counter_r, counter_nxt;
  count_t               nal_cnt_r, nal_cnt_nxt;
  count_t               vcl_cnt_r, vcl_cnt_nxt;
  logic [KIND_BITS-1:0] mask_r, mask_nxt;
  count_t               pend_cnt_r, pend_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  slice_t               stored_r, stored_nxt;
  index_t               first_nal_r, first_nal_nxt;
  index_t               first_vcl_r, first_vcl_nxt;
  index_t               last_nal_r, last_nal_nxt;
  index_t               pend_first_r, pend_first_nxt;
  result_t              out_data_r, out_data_nxt;

  logic   advance;
  logic   new_pic;
  logic   emit;
  logic   start;
  logic   append;
  logic   add_pend;
  slice_t s;

  assign s       = q_item.slice;
  assign advance = q_valid && (!out_valid_r || out_tready);
  assign q_pop   = advance;

  // New picture on a changed first-slice field; bottom needs fields, IDR id IDRs.
  always_comb begin
    new_pic = (stored_r.frame_number != s.frame_number) ||
              (stored_r.pps_id != s.pps_id) ||
              (stored_r.field != s.field) ||
              (stored_r.field && s.field && stored_r.bottom != s.bottom) ||
              (stored_r.reference != s.reference) ||
              (stored_r.poc_lsb != s.poc_lsb) ||
              (stored_r.delta_poc_bottom != s.delta_poc_bottom) ||
              (stored_r.delta_poc_first != s.delta_poc_first) ||
              (stored_r.delta_poc_second != s.delta_poc_second) ||
              (stored_r.idr != s.idr) ||
              (stored_r.idr && s.idr && stored_r.idr_picture_id != s.idr_picture_id);
  end

  always_comb begin
    emit     = 1'b0;
    start    = 1'b0;
    append   = 1'b0;
    add_pend = 1'b0;
    if (advance) begin
      case (q_item.cls)
        CLS_FINISH: emit = open_r;
        CLS_VCL: begin
          start  = !open_r || new_pic;
          emit   = open_r && new_pic;
          append = open_r && !new_pic;
        end
        CLS_PREFIX: begin
          emit     = open_r;
          add_pend = 1'b1;
        end
        default: begin
          append   = open_r;
          add_pend = !open_r;
        end
      endcase
    end
  end

  always_comb begin
    open_nxt       = open_r;
    counter_nxt    = counter_r;
    nal_cnt_nxt    = nal_cnt_r;
    vcl_cnt_nxt    = vcl_cnt_r;
    mask_nxt       = mask_r;
    pend_cnt_nxt   = pend_cnt_r;
    stored_nxt     = stored_r;
    first_nal_nxt  = first_nal_r;
    first_vcl_nxt  = first_vcl_r;
    last_nal_nxt   = last_nal_r;
    pend_first_nxt = pend_first_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (emit) begin
      open_nxt                      = 1'b0;
      out_valid_nxt                 = 1'b1;
      out_data_nxt.unit_number      = counter_r - 1'b1;
      out_data_nxt.first_nal        = first_nal_r;
      out_data_nxt.first_vcl_nal    = first_vcl_r;
      out_data_nxt.last_nal         = last_nal_r;
      out_data_nxt.nal_total        = nal_cnt_r;
      out_data_nxt.vcl_total        = vcl_cnt_r;
      out_data_nxt.slice_kinds_seen = mask_r;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (start) begin
      // Pending prefixes are folded into the new unit.
      open_nxt      = 1'b1;
      counter_nxt   = counter_r + 1'b1;
      first_nal_nxt = (pend_cnt_r != '0) ? pend_first_r : q_item.pos;
      nal_cnt_nxt   = sat_inc(pend_cnt_r);
      vcl_cnt_nxt   = count_t'(1);
      mask_nxt      = q_item.kind_bit;
      stored_nxt    = s;
      first_vcl_nxt = q_item.pos;
      last_nal_nxt  = q_item.pos;
      pend_cnt_nxt  = '0;
    end

    if (append) begin
      last_nal_nxt = q_item.pos;
      nal_cnt_nxt  = sat_inc(nal_cnt_r);
      if (q_item.cls == CLS_VCL) begin
        vcl_cnt_nxt = sat_inc(vcl_cnt_r);
        mask_nxt    = mask_r | q_item.kind_bit;
      end
    end

    if (add_pend) begin
      if (pend_cnt_r == '0) begin
        pend_first_nxt = q_item.pos;
      end
      pend_cnt_nxt = sat_inc(pend_cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b0;
      counter_r   <= '0;
      nal_cnt_r   <= '0;
      vcl_cnt_r   <= '0;
      mask_r      <= '0;
      pend_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      open_r      <= open_nxt;
      counter_r   <= counter_nxt;
      nal_cnt_r   <= nal_cnt_nxt;
      vcl_cnt_r   <= vcl_cnt_nxt;
      mask_r      <= mask_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stored_r     <= stored_nxt;
    first_nal_r  <= first_nal_nxt;
    first_vcl_r  <= first_vcl_nxt;
    last_nal_r   <= last_nal_nxt;
    pend_first_r <= pend_first_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_data_r};

  `AUBD_ASSERT_IMPLY(a_open_has_vcl, open_r, vcl_cnt_r != '0, "open unit without a VCL word")
  `AUBD_ASSERT_IMPLY(a_nal_covers_vcl, open_r, nal_cnt_r >= vcl_cnt_r, "NAL count below VCL count")
  `AUBD_ASSERT_NEXT(a_emit_shows, emit, out_valid_r && !open_r || out_valid_r && $past(start), "emitted unit not presented")

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the H.264 access unit boundary detector.
module tb_top
  import aubd_pkg::*;
;

  localparam bit CMD_PUSH   = 1'b0;
  localparam bit CMD_FINISH = 1'b1;

  // Masks for the picture_flags field.
  localparam logic [4:0] FL_SLICE  = 5'b00001;
  localparam logic [4:0] FL_FIELD  = 5'b00010;
  localparam logic [4:0] FL_BOTTOM = 5'b00100;
  localparam logic [4:0] FL_IDR    = 5'b01000;
  localparam logic [4:0] FL_REF    = 5'b10000;

  localparam int RANDOM_WORDS = 700;

  typedef struct {
    bit        cmd;
    bit [31:0] pos;
    bit [4:0]  ntype;
    bit [4:0]  flags;
    bit [15:0] frame;
    bit [7:0]  pps;
    bit [15:0] poc;
    bit [31:0] dpb;
    bit [31:0] dp0;
    bit [31:0] dp1;
    bit [15:0] idr_id;
    bit [2:0]  kind;
  } nal_word_t;

  // Groups accepted NAL words into access units and holds the units still owed.
  class access_unit_board;
    result_t  expected_units[$];
    int       units_checked = 0;
    bit       unit_open = 0;
    bit [31:0] unit_counter = '0;
    slice_t   first_slice;
    result_t  open_unit;
    index_t   prefix_first;
    count_t   prefix_count = '0;

    function count_t bump(count_t v);
      return (v == '1) ? v : count_t'(v + 1);
    endfunction

    function logic [KIND_BITS-1:0] kind_mask(bit [2:0] kind);
      return (kind <= KIND_MAX) ? KIND_BITS'(1) << kind : '0;
    endfunction

    function bit differs(slice_t a, slice_t b);
      if (a.frame_number != b.frame_number || a.pps_id != b.pps_id || a.field != b.field)
        return 1;
      if (a.field && b.field && a.bottom != b.bottom) return 1;
      if (a.reference != b.reference) return 1;
      if (a.poc_lsb != b.poc_lsb || a.delta_poc_bottom != b.delta_poc_bottom ||
          a.delta_poc_first != b.delta_poc_first ||
          a.delta_poc_second != b.delta_poc_second)
        return 1;
      if (a.idr != b.idr) return 1;
      return a.idr && b.idr && a.idr_picture_id != b.idr_picture_id;
    endfunction

    function void close_unit();
      if (unit_open) expected_units.insert(expected_units.size(), open_unit);
      unit_open = 0;
    endfunction

    function void start_unit(nal_word_t w, slice_t s);
      open_unit.unit_number      = unit_counter;
      open_unit.first_nal        = (prefix_count != 0) ? prefix_first : w.pos;
      open_unit.nal_total        = bump(prefix_count);
      open_unit.first_vcl_nal    = w.pos;
      open_unit.last_nal         = w.pos;
      open_unit.vcl_total        = count_t'(1);
      open_unit.slice_kinds_seen = kind_mask(w.kind);
      first_slice  = s;
      prefix_count = '0;
      unit_counter = unit_counter + 1;
      unit_open    = 1;
    endfunction

    function void hold_prefix(bit [31:0] pos);
      if (prefix_count == 0) prefix_first = pos;
      prefix_count = bump(prefix_count);
    endfunction

    function void take_nal(nal_word_t w);
      slice_t s;
      bit     is_vcl;
      bit     is_prefix;
      if (w.cmd == CMD_FINISH) begin
        close_unit();
        return;
      end
      is_vcl = (w.ntype == NAL_SLICE || w.ntype == NAL_IDR) && (w.flags & FL_SLICE) != 0;
      is_prefix = (w.ntype >= NAL_SEI && w.ntype <= NAL_AUD) ||
                  (w.ntype >= NAL_PFX_LO && w.ntype <= NAL_PFX_HI);
      if (is_vcl) begin
        s.frame_number     = w.frame;
        s.pps_id           = w.pps;
        s.field            = (w.flags & FL_FIELD) != 0;
        s.bottom           = (w.flags & FL_BOTTOM) != 0;
        s.idr              = (w.flags & FL_IDR) != 0;
        s.reference        = (w.flags & FL_REF) != 0;
        s.poc_lsb          = w.poc;
        s.delta_poc_bottom = w.dpb;
        s.delta_poc_first  = w.dp0;
        s.delta_poc_second = w.dp1;
        s.idr_picture_id   = w.idr_id;
        if (!unit_open) begin
          start_unit(w, s);
        end else if (differs(first_slice, s)) begin
          close_unit();
          start_unit(w, s);
        end else begin
          open_unit.last_nal         = w.pos;
          open_unit.nal_total        = bump(open_unit.nal_total);
          open_unit.vcl_total        = bump(open_unit.vcl_total);
          open_unit.slice_kinds_seen = open_unit.slice_kinds_seen | kind_mask(w.kind);
        end
      end else if (is_prefix) begin
        close_unit();
        hold_prefix(w.pos);
      end else if (unit_open) begin
        open_unit.last_nal  = w.pos;
        open_unit.nal_total = bump(open_unit.nal_total);
      end else begin
        hold_prefix(w.pos);
      end
    endfunction

    // Returns an empty string when the word matches the oldest owed unit.
    function string match_unit(logic [OUT_DATA_BITS-1:0] data);
      result_t got;
      result_t want;
      string   msg;
      got = data[$bits(result_t)-1:0];
      if (expected_units.size() == 0)
        return $sformatf("unexpected unit word %h", got);
      want = expected_units.pop_front();
      units_checked++;
      msg = "";
      if (got.unit_number != want.unit_number)
        msg = {msg, $sformatf(" unit_number %0d/%0d", got.unit_number, want.unit_number)};
      if (got.first_nal != want.first_nal)
        msg = {msg, $sformatf(" first_nal %h/%h", got.first_nal, want.first_nal)};
      if (got.first_vcl_nal != want.first_vcl_nal)
        msg = {msg, $sformatf(" first_vcl_nal %h/%h", got.first_vcl_nal, want.first_vcl_nal)};
      if (got.last_nal != want.last_nal)
        msg = {msg, $sformatf(" last_nal %h/%h", got.last_nal, want.last_nal)};
      if (got.nal_total != want.nal_total)
        msg = {msg, $sformatf(" nal_total %0d/%0d", got.nal_total, want.nal_total)};
      if (got.vcl_total != want.vcl_total)
        msg = {msg, $sformatf(" vcl_total %0d/%0d", got.vcl_total, want.vcl_total)};
      if (got.slice_kinds_seen != want.slice_kinds_seen)
        msg = {msg, $sformatf(" slice_kinds_seen %b/%b", got.slice_kinds_seen,
                              want.slice_kinds_seen)};
      if (msg != "")
        msg = {$sformatf("unit %0d (got/expected):", want.unit_number), msg};
      return msg;
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic                     in_tuser = 1'b0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;

  access_unit_board board;
  nal_word_t        cur_pic;
  bit [31:0]        next_pos = '0;
  bit               no_gaps = 1'b0;
  int               mismatches = 0;
  int               words_sent = 0;

  h264_access_unit_boundary_detector_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic nal_word_t nal(bit cmd, bit [31:0] pos, bit [4:0] ntype,
                                    bit [4:0] flags, bit [2:0] kind);
    nal_word_t w;
    w       = cur_pic;
    w.cmd   = cmd;
    w.pos   = pos;
    w.ntype = ntype;
    w.flags = flags;
    w.kind  = kind;
    return w;
  endfunction

  function automatic nal_word_t scramble(nal_word_t w);
    w.flags  = 5'($urandom);
    w.frame  = 16'($urandom);
    w.pps    = 8'($urandom);
    w.poc    = 16'($urandom);
    w.dpb    = $urandom;
    w.dp0    = $urandom;
    w.dp1    = $urandom;
    w.idr_id = 16'($urandom);
    return w;
  endfunction

  // Mostly running-picture slices, with new pictures, prefixes, finishes and noise.
  function automatic nal_word_t random_nal();
    nal_word_t w;
    int        pick;
    pick = $urandom_range(99);
    if ($urandom_range(49) == 0) next_pos = $urandom;
    w = nal(CMD_PUSH, next_pos, NAL_SLICE, cur_pic.flags,
            ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4)));
    next_pos++;
    if (pick < 8) begin
      w       = scramble(w);
      w.cmd   = CMD_FINISH;
      w.ntype = 5'($urandom);
    end else if (pick < 22) begin
      w       = scramble(w);
      w.ntype = $urandom_range(1) ? 5'($urandom_range(NAL_SEI, NAL_AUD))
                                  : 5'($urandom_range(NAL_PFX_LO, NAL_PFX_HI));
    end else if (pick < 32) begin
      w       = scramble(w);
      w.ntype = 5'($urandom);
      if (w.ntype == NAL_SLICE || w.ntype == NAL_IDR) w.flags = w.flags & ~FL_SLICE;
    end else begin
      if (pick < 50) begin
        case ($urandom_range(12))
          0:  cur_pic.frame = 16'(cur_pic.frame + 1);
          1:  cur_pic.pps = 8'($urandom);
          2:  cur_pic.flags = cur_pic.flags ^ FL_FIELD;
          3:  cur_pic.flags = (cur_pic.flags | FL_FIELD) ^ FL_BOTTOM;
          4:  cur_pic.flags = cur_pic.flags ^ FL_REF;
          5:  cur_pic.poc = 16'($urandom);
          6:  cur_pic.dpb = $urandom;
          7:  cur_pic.dp0 = $urandom;
          8:  cur_pic.dp1 = $urandom;
          9:  cur_pic.flags = cur_pic.flags ^ FL_IDR;
          10: begin
            cur_pic.flags  = cur_pic.flags | FL_IDR;
            cur_pic.idr_id = cur_pic.idr_id + 16'($urandom_range(1, 65535));
          end
          default: cur_pic = scramble(cur_pic);
        endcase
        cur_pic.flags = cur_pic.flags | FL_SLICE;
      end
      w.frame = cur_pic.frame;
      w.pps   = cur_pic.pps;
      w.poc   = cur_pic.poc;
      w.dpb   = cur_pic.dpb;
      w.dp0   = cur_pic.dp0;
      w.dp1   = cur_pic.dp1;
      w.flags = cur_pic.flags;
      w.ntype = $urandom_range(1) ? NAL_IDR : NAL_SLICE;
      // Bottom and the IDR picture id are only compared for field and IDR pictures.
      if ((w.flags & FL_FIELD) == 0 && $urandom_range(1)) w.flags = w.flags ^ FL_BOTTOM;
      w.idr_id = ((w.flags & FL_IDR) == 0) ? 16'($urandom) : cur_pic.idr_id;
    end
    return w;
  endfunction

  task automatic push_word(nal_word_t w);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= w.cmd;
    in_tdata  <= {3'b000, w.kind, w.idr_id, w.dp1, w.dp0, w.dpb, w.poc, w.pps, w.frame,
                  w.flags, w.ntype, w.pos};
    do @(posedge clk); while (!in_tready);
    board.take_nal(w);
    words_sent++;
    if (!no_gaps && $urandom_range(3) == 0) begin
      gap = ($urandom_range(19) < 17) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side stalls: short runs of ready with short stalls, now and then a long one.
  initial begin
    int run;
    repeat (4) @(posedge clk);
    forever begin
      run = ($urandom_range(9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      out_tready <= 1'b1;
      repeat (run) @(posedge clk);
      run = ($urandom_range(9) < 8) ? $urandom_range(1, 4) : $urandom_range(20, 60);
      out_tready <= 1'b0;
      repeat (run) @(posedge clk);
    end
  end

  always @(posedge clk) begin : watch_units
    string msg;
    if (rst_n && out_tvalid && out_tready) begin
      msg = board.match_unit(out_tdata);
      if (msg != "") report(msg);
    end
  end

  initial begin
    int drain;
    board = new;
    cur_pic = '{cmd: CMD_PUSH, pos: '0, ntype: '0, flags: FL_SLICE, frame: 16'hFFFF,
                pps: 8'hFF, poc: 16'hFFFF, dpb: 32'h7FFF_FFFF, dp0: 32'h8000_0001,
                dp1: 32'hFFFF_FFFF, idr_id: 16'hFFFF, kind: '0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: prefixes before a picture, finish with nothing open, unknown slice
    // kind, cleared slice flag, descending indices, IDR id, bottom and reference changes.
    push_word(nal(CMD_PUSH, 0, NAL_SEI, 5'b0, 0));
    push_word(nal(CMD_FINISH, 1, 5'd0, 5'b0, 0));
    push_word(nal(CMD_PUSH, 2, NAL_IDR, FL_SLICE | FL_IDR | FL_REF | FL_FIELD, 2));
    push_word(nal(CMD_PUSH, 3, NAL_SLICE, FL_SLICE | FL_IDR | FL_REF | FL_FIELD, 7));
    push_word(nal(CMD_PUSH, 4, 5'd12, 5'b0, 0));
    push_word(nal(CMD_PUSH, 5, NAL_SLICE, FL_IDR | FL_REF, 3));
    push_word(nal(CMD_PUSH, 3, NAL_IDR, FL_SLICE | FL_IDR | FL_REF | FL_FIELD, 4));
    cur_pic.idr_id = '0;
    push_word(nal(CMD_PUSH, 6, NAL_IDR, FL_SLICE | FL_IDR | FL_REF | FL_FIELD, 0));
    push_word(nal(CMD_PUSH, 7, NAL_AUD, 5'b0, 0));
    push_word(nal(CMD_PUSH, 8, 5'd31, 5'b11111, 6));
    push_word(nal(CMD_PUSH, 9, NAL_PFX_HI, 5'b0, 0));
    cur_pic = '{cmd: CMD_PUSH, pos: '0, ntype: '0, flags: FL_SLICE, frame: '0, pps: '0,
                poc: '0, dpb: '0, dp0: '0, dp1: '0, idr_id: '0, kind: '0};
    push_word(nal(CMD_PUSH, 32'hFFFF_FFFF, NAL_SLICE, FL_SLICE, 0));
    for (int k = 1; k <= 4; k++)
      push_word(nal(CMD_PUSH, 9 + k, NAL_SLICE, FL_SLICE | ((k % 2) ? FL_BOTTOM : 5'b0),
                    3'(k)));
    push_word(nal(CMD_FINISH, 0, 5'd0, 5'b0, 0));
    push_word(nal(CMD_FINISH, 0, 5'd0, 5'b0, 0));
    push_word(nal(CMD_PUSH, 14, NAL_PFX_LO, 5'b0, 0));
    push_word(nal(CMD_PUSH, 15, NAL_SLICE, FL_SLICE | FL_FIELD | FL_BOTTOM, 1));
    push_word(nal(CMD_PUSH, 16, NAL_SLICE, FL_SLICE | FL_FIELD, 1));
    push_word(nal(CMD_PUSH, 17, NAL_SLICE, FL_SLICE | FL_FIELD | FL_REF, 1));
    push_word(nal(CMD_PUSH, 18, 5'd8, 5'b0, 0));

    // Random part, with some stretches sent back to back.
    next_pos = 32'd100;
    cur_pic = scramble(cur_pic);
    cur_pic.flags = cur_pic.flags | FL_SLICE;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 50 == 0) no_gaps = ($urandom_range(3) == 0);
      push_word(random_nal());
    end
    push_word(nal(CMD_FINISH, 0, 5'd0, 5'b0, 0));
    in_tvalid <= 1'b0;

    drain = 0;
    while (board.expected_units.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (board.expected_units.size() != 0)
      report($sformatf("%0d access units never delivered", board.expected_units.size()));

    $display("Sent %0d NAL words in a directed part and a random part;", words_sent);
    $display("checked %0d completed access units against the predictor.",
             board.units_checked);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("Timeout with %0d access units still owed", board.expected_units.size());
    $display("Verification failed");
    $finish;
  end

endmodule
